FILE: rtl/glu_pkg.sv
// glu_pkg: widths, constants and the sigmoid breakpoint table shared by the glu files
package glu_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int IDX_W      = 4;
  localparam int SEG_FRAC_W = 11;
  localparam int SIG_W      = 13;
  localparam int DELTA_W    = 10;
  localparam int PROD_W     = DELTA_W + SEG_FRAC_W;
  localparam int PRODUCT_W  = DATA_W + SIG_W + 1;
  localparam int TDATA_IN_W = 2 * DATA_W;
  localparam int STAGES     = 7;

  localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << FRAC_W;

  // sigmoid(k/2) in q.12, rounded half up, k = 0..16
  function automatic logic [SIG_W-1:0] sig_lut(input logic [IDX_W:0] k);
    logic [SIG_W-1:0] v;
    unique case (k)
      5'd0:    v = 13'd2048;
      5'd1:    v = 13'd2550;
      5'd2:    v = 13'd2994;
      5'd3:    v = 13'd3349;
      5'd4:    v = 13'd3608;
      5'd5:    v = 13'd3785;
      5'd6:    v = 13'd3902;
      5'd7:    v = 13'd3976;
      5'd8:    v = 13'd4022;
      5'd9:    v = 13'd4051;
      5'd10:   v = 13'd4069;
      5'd11:   v = 13'd4079;
      5'd12:   v = 13'd4086;
      5'd13:   v = 13'd4090;
      5'd14:   v = 13'd4092;
      5'd15:   v = 13'd4094;
      5'd16:   v = 13'd4095;
      default: v = 13'd4095;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/gated_linear_unit_activation.sv
// gated_linear_unit_activation: pipelined first * sigmoid(gate) in signed q4.12
//
//  channel | direction | tdata fields (low bit first)              | tuser/tlast
//  in_     | slave     | first_value[15:0], gate_value[31:16]      | none
//  out_    | master    | gated_value[15:0]                         | none
//
// seven register stages, stage 0 to stage 6; one item is taken every cycle
// when the output flows.
// each stage has its own valid bit and a stage loads when it is empty or
// its successor moves, so bubbles close up and a stall drops nothing.
// rst_n clears the valid bits only; payload registers are not reset.
module gated_linear_unit_activation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [glu_pkg::TDATA_IN_W-1:0] in_tdata,  // first_value, gate_value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [glu_pkg::DATA_W-1:0]    out_tdata   // gated_value
);
  import glu_pkg::*;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic [STAGES-1:0] en;

  // stage 0: raw inputs
  logic signed [DATA_W-1:0] a0_r, g0_r;
  // stage 1: magnitude split into segment and fraction
  logic signed [DATA_W-1:0] a1_r;
  logic                     neg1_r, big1_r;
  logic [IDX_W-1:0]         idx1_r;
  logic [SEG_FRAC_W-1:0]    frac1_r;
  // stage 2: breakpoint and slope
  logic signed [DATA_W-1:0] a2_r;
  logic                     neg2_r, big2_r;
  logic [SIG_W-1:0]         lo2_r;
  logic [DELTA_W-1:0]       d2_r;
  logic [SEG_FRAC_W-1:0]    frac2_r;
  // stage 3: slope times fraction
  logic signed [DATA_W-1:0] a3_r;
  logic                     neg3_r, big3_r;
  logic [SIG_W-1:0]         lo3_r;
  logic [PROD_W-1:0]        prod3_r;
  // stage 4: sigmoid
  logic signed [DATA_W-1:0] a4_r;
  logic [SIG_W-1:0]         s4_r;
  // stage 5: full product
  logic signed [PRODUCT_W-1:0] p5_r;
  // stage 6: output register
  logic [DATA_W-1:0]        q6_r;

  // per-stage load enables, from the output backwards
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_tvalid;
    for (int i = 1; i < STAGES; i++) begin
      if (en[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1 logic
  logic signed [DATA_W:0] gx;
  logic [DATA_W:0]        mag1;
  assign gx   = {g0_r[DATA_W-1], g0_r};
  assign mag1 = g0_r[DATA_W-1] ? unsigned'(-gx) : unsigned'(gx);

  // stage 2 logic
  logic [SIG_W-1:0] lo_c, hi_c;
  assign lo_c = sig_lut({1'b0, idx1_r});
  assign hi_c = sig_lut({1'b0, idx1_r} + (IDX_W+1)'(1));

  // stage 4 logic
  logic [PROD_W-1:0] interp_full;
  logic [SIG_W-1:0]  s_pos, s_mag, s_fin;
  assign interp_full = (prod3_r + (PROD_W'(1) << (SEG_FRAC_W - 1))) >> SEG_FRAC_W;
  assign s_pos = lo3_r + SIG_W'(interp_full);
  assign s_mag = big3_r ? SIG_ONE : s_pos;
  assign s_fin = neg3_r ? SIG_ONE - s_mag : s_mag;

  // stage 6 logic: round half away from zero, then saturate
  logic [PRODUCT_W-1:0]        pmag, rsum;
  logic [PRODUCT_W-FRAC_W-1:0] rmag;
  logic signed [PRODUCT_W-FRAC_W:0] qs;
  logic [DATA_W-1:0]           q_sat;
  localparam logic signed [PRODUCT_W-FRAC_W:0] QMAX =
    (PRODUCT_W-FRAC_W+1)'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [PRODUCT_W-FRAC_W:0] QMIN = -QMAX - 1;

  always_comb begin
    pmag = p5_r[PRODUCT_W-1] ? unsigned'(-p5_r) : unsigned'(p5_r);
    rsum = pmag + (PRODUCT_W'(1) << (FRAC_W - 1));
    rmag = rsum[PRODUCT_W-1:FRAC_W];
    qs   = p5_r[PRODUCT_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    if (qs > QMAX) begin
      q_sat = QMAX[DATA_W-1:0];
    end else if (qs < QMIN) begin
      q_sat = QMIN[DATA_W-1:0];
    end else begin
      q_sat = qs[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r <= in_tdata[DATA_W-1:0];
      g0_r <= in_tdata[TDATA_IN_W-1:DATA_W];
    end
    if (en[1]) begin
      a1_r    <= a0_r;
      neg1_r  <= g0_r[DATA_W-1];
      big1_r  <= mag1[DATA_W-1];
      idx1_r  <= mag1[SEG_FRAC_W+IDX_W-1:SEG_FRAC_W];
      frac1_r <= mag1[SEG_FRAC_W-1:0];
    end
    if (en[2]) begin
      a2_r    <= a1_r;
      neg2_r  <= neg1_r;
      big2_r  <= big1_r;
      lo2_r   <= lo_c;
      d2_r    <= DELTA_W'(hi_c - lo_c);
      frac2_r <= frac1_r;
    end
    if (en[3]) begin
      a3_r    <= a2_r;
      neg3_r  <= neg2_r;
      big3_r  <= big2_r;
      lo3_r   <= lo2_r;
      prod3_r <= PROD_W'(d2_r) * PROD_W'(frac2_r);
    end
    if (en[4]) begin
      a4_r <= a3_r;
      s4_r <= s_fin;
    end
    if (en[5]) begin
      p5_r <= PRODUCT_W'(a4_r) * $signed({1'b0, s4_r});
    end
    if (en[6]) begin
      q6_r <= q_sat;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = q6_r;

endmodule

FILE: rtl/glu_checker.sv
// glu_checker: port-level assertions for gated_linear_unit_activation, with its bind
module glu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [glu_pkg::TDATA_IN_W-1:0] in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [glu_pkg::DATA_W-1:0]    out_tdata
);
  import glu_pkg::*;

  // a held result keeps its value until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // a waiting input transfer is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input changed or dropped while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  // an empty output stage means nothing can block the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // after reset no result can show before a transfer has crossed the pipeline
  a_no_early_result: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_tvalid [*STAGES-1])
    else $error("result appeared before any transfer");

endmodule

bind gated_linear_unit_activation glu_checker u_glu_checker (.*);
